>>> sv/lvc_pkg.sv
// ----------------------------------------------------------------------------
// Level-set curvature package
// Widths and step counts shared by the curvature pipeline and its checker.
// ----------------------------------------------------------------------------
package lvc_pkg;

    localparam int SampleW = 16;
    localparam int CfgW    = 32;
    localparam int GridW   = 11;
    localparam int ResW    = 32;

    localparam int GradW   = SampleW + 1;
    localparam int SecW    = SampleW + 2;
    localparam int SqW     = 2 * SampleW;
    localparam int SumW    = SqW + 1;
    localparam int TermW   = SecW + SqW;
    localparam int NumW    = TermW + 3;
    localparam int MagW    = NumW - 1;
    localparam int ProdW   = GridW + MagW;

    localparam int SqrtFrac = 13;
    localparam int XPad     = 2 * SqrtFrac;
    localparam int XW       = 60;
    localparam int SqSteps  = XW / 2;
    localparam int RootW    = SqSteps;
    localparam int RemW     = RootW + 1;
    localparam int DenW     = SumW + RootW;

    localparam int PreShift = 3;
    localparam int DivSteps = 33;
    localparam int QW       = DivSteps;

    localparam logic CfgGridSize  = 1'b0;
    localparam logic CfgMinGradSq = 1'b1;

endpackage

>>> sv/level_set_curvature.sv
// ----------------------------------------------------------------------------
// Level-set mean curvature, 2-D central differences
// Pipelined curvature of a 3x3 level-set neighborhood in signed Q16.16.
//
//   channel | direction | handshake          | payload
//   input   | in        | i_valid / o_ready  | nine phi samples, interior
//   output  | out       | o_valid / i_ready  | curvature, two flags
//   config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One cell enters per cycle while the pipeline is not held; the 30 square-root
// stages and the 33 quotient stages produce one bit each.
// Reset is synchronous; it clears the valid bits and sets the grid size to 128 and the threshold to zero.
// When the output register is full and not taken, the whole pipeline holds.
// ----------------------------------------------------------------------------
module level_set_curvature import lvc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [CfgW-1:0]           i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [SampleW-1:0] i_phi_center,
    input  logic signed [SampleW-1:0] i_phi_left,
    input  logic signed [SampleW-1:0] i_phi_right,
    input  logic signed [SampleW-1:0] i_phi_down,
    input  logic signed [SampleW-1:0] i_phi_up,
    input  logic signed [SampleW-1:0] i_phi_right_up,
    input  logic signed [SampleW-1:0] i_phi_right_down,
    input  logic signed [SampleW-1:0] i_phi_left_up,
    input  logic signed [SampleW-1:0] i_phi_left_down,
    input  logic                      i_interior,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [ResW-1:0]    o_curvature,
    output logic                      o_flat_or_border,
    output logic                      o_saturated
);

    logic adv;

    logic [GridW-1:0] r_grid;
    logic [CfgW-1:0]  r_min;

    // stage 1: differences
    logic                    r_s1_vld, r_s1_int;
    logic signed [GradW-1:0] r_s1_ax, r_s1_ay;
    logic signed [SecW-1:0]  r_s1_bxx, r_s1_byy, r_s1_cxy;
    // stage 2: squares
    logic                    r_s2_vld, r_s2_int;
    logic [SqW-1:0]          r_s2_axx, r_s2_ayy;
    logic signed [SqW:0]     r_s2_axy;
    logic signed [SecW-1:0]  r_s2_bxx, r_s2_byy, r_s2_cxy;
    // stage 3: terms
    logic                    r_s3_vld, r_s3_flat;
    logic [SumW-1:0]         r_s3_s;
    logic signed [TermW-1:0] r_s3_t1, r_s3_t2, r_s3_t3;
    // stage 4: numerator
    logic                    r_s4_vld, r_s4_flat, r_s4_neg;
    logic [SumW-1:0]         r_s4_s;
    logic [MagW-1:0]         r_s4_mag;
    // stage 5: scaled numerator
    logic                    r_s5_vld, r_s5_flat, r_s5_neg;
    logic [SumW-1:0]         r_s5_s;
    logic [ProdW-1:0]        r_s5_p;

    // square-root stages
    logic [SqSteps-1:0] r_sq_vld;
    logic               r_sq_flat [SqSteps];
    logic               r_sq_neg  [SqSteps];
    logic [SumW-1:0]    r_sq_s    [SqSteps];
    logic [ProdW-1:0]   r_sq_p    [SqSteps];
    logic [RootW-1:0]   r_sq_root [SqSteps];
    logic [RemW-1:0]    r_sq_rem  [SqSteps];
    logic [RootW-1:0]   n_sq_root [SqSteps];
    logic [RemW-1:0]    n_sq_rem  [SqSteps];

    // denominator and pre-check
    logic               r_dn_vld, r_dn_flat, r_dn_neg;
    logic [ProdW-1:0]   r_dn_p;
    logic [DenW-1:0]    r_dn_den;
    logic               r_pc_vld, r_pc_flat, r_pc_neg, r_pc_ovf;
    logic [PreShift-1:0] r_pc_plo;
    logic [DenW-1:0]    r_pc_den, r_pc_r;

    // quotient stages
    logic [DivSteps-1:0] r_dv_vld;
    logic                r_dv_flat [DivSteps];
    logic                r_dv_neg  [DivSteps];
    logic                r_dv_ovf  [DivSteps];
    logic [PreShift-1:0] r_dv_plo  [DivSteps];
    logic [DenW-1:0]     r_dv_den  [DivSteps];
    logic [DenW-1:0]     r_dv_r    [DivSteps];
    logic [QW-1:0]       r_dv_q    [DivSteps];
    logic [DenW-1:0]     n_dv_r    [DivSteps];
    logic [QW-1:0]       n_dv_q    [DivSteps];

    // output register
    logic                  r_out_vld, r_out_flat, r_out_sat;
    logic signed [ResW-1:0] r_out_k;
    logic                  n_out_sat;
    logic signed [ResW-1:0] n_out_k;

    assign adv     = !r_out_vld || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= GridW'(128);
            r_min  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgGridSize:  r_grid <= i_cfg_data[GridW-1:0];
                CfgMinGradSq: r_min  <= i_cfg_data;
                default:      r_grid <= r_grid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_sq_vld  <= '0;
            r_dn_vld  <= 1'b0;
            r_pc_vld  <= 1'b0;
            r_dv_vld  <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld  <= i_valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_sq_vld  <= {r_sq_vld[SqSteps-2:0], r_s5_vld};
            r_dn_vld  <= r_sq_vld[SqSteps-1];
            r_pc_vld  <= r_dn_vld;
            r_dv_vld  <= {r_dv_vld[DivSteps-2:0], r_pc_vld};
            r_out_vld <= r_dv_vld[DivSteps-1];
        end
    end

    always_comb begin
        for (int j = 0; j < SqSteps; j++) begin
            logic [RootW-1:0] root;
            logic [RemW-1:0]  rem;
            logic [SumW-1:0]  s;
            logic [XW-1:0]    x;
            logic [RemW+1:0]  ext;
            logic [RemW+1:0]  trial;
            root  = (j == 0) ? '0 : r_sq_root[(j == 0) ? 0 : j-1];
            rem   = (j == 0) ? '0 : r_sq_rem[(j == 0) ? 0 : j-1];
            s     = (j == 0) ? r_s5_s : r_sq_s[(j == 0) ? 0 : j-1];
            x     = {1'b0, s, XPad'(0)};
            ext   = {rem, x[2*(SqSteps-1-j) +: 2]};
            trial = {1'b0, root, 2'b01};
            if (ext >= trial) begin
                n_sq_rem[j]  = RemW'(ext - trial);
                n_sq_root[j] = {root[RootW-2:0], 1'b1};
            end else begin
                n_sq_rem[j]  = RemW'(ext);
                n_sq_root[j] = {root[RootW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        for (int k = 0; k < DivSteps; k++) begin
            logic [DenW-1:0]     r;
            logic [DenW-1:0]     den;
            logic [QW-1:0]       q;
            logic [PreShift-1:0] plo;
            logic                nb;
            logic [DenW:0]       sh;
            r   = (k == 0) ? r_pc_r   : r_dv_r[(k == 0) ? 0 : k-1];
            den = (k == 0) ? r_pc_den : r_dv_den[(k == 0) ? 0 : k-1];
            q   = (k == 0) ? '0       : r_dv_q[(k == 0) ? 0 : k-1];
            plo = (k == 0) ? r_pc_plo : r_dv_plo[(k == 0) ? 0 : k-1];
            nb  = (k < PreShift) ? plo[(k < PreShift) ? PreShift-1-k : 0] : 1'b0;
            sh  = {r, nb};
            if (sh >= {1'b0, den}) begin
                n_dv_r[k] = DenW'(sh - {1'b0, den});
                n_dv_q[k] = {q[QW-2:0], 1'b1};
            end else begin
                n_dv_r[k] = DenW'(sh);
                n_dv_q[k] = {q[QW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [QW:0]   qp1;
        logic [QW-1:0] m;
        logic [QW-1:0] lim;
        logic [ResW-1:0] mm;
        qp1 = {1'b0, r_dv_q[DivSteps-1]} + (QW+1)'(1);
        m   = qp1[QW:1];
        lim = r_dv_neg[DivSteps-1] ? QW'(33'h0_8000_0000) : QW'(33'h0_7FFF_FFFF);
        n_out_sat = r_dv_ovf[DivSteps-1] || (m > lim);
        mm  = n_out_sat ? lim[ResW-1:0] : m[ResW-1:0];
        n_out_k = r_dv_neg[DivSteps-1] ? -$signed(mm) : $signed(mm);
        if (r_dv_flat[DivSteps-1]) begin
            n_out_sat = 1'b0;
            n_out_k   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_ax  <= GradW'(i_phi_right) - GradW'(i_phi_left);
            r_s1_ay  <= GradW'(i_phi_up) - GradW'(i_phi_down);
            r_s1_bxx <= SecW'(i_phi_right) + SecW'(i_phi_left) - (SecW'(i_phi_center) <<< 1);
            r_s1_byy <= SecW'(i_phi_up) + SecW'(i_phi_down) - (SecW'(i_phi_center) <<< 1);
            r_s1_cxy <= SecW'(i_phi_right_up) - SecW'(i_phi_right_down)
                        - SecW'(i_phi_left_up) + SecW'(i_phi_left_down);
            r_s1_int <= i_interior;

            r_s2_axx <= $unsigned(SqW'(r_s1_ax) * SqW'(r_s1_ax));
            r_s2_ayy <= $unsigned(SqW'(r_s1_ay) * SqW'(r_s1_ay));
            r_s2_axy <= (SqW+1)'(r_s1_ax) * (SqW+1)'(r_s1_ay);
            r_s2_bxx <= r_s1_bxx;
            r_s2_byy <= r_s1_byy;
            r_s2_cxy <= r_s1_cxy;
            r_s2_int <= r_s1_int;

            r_s3_s    <= SumW'(r_s2_axx) + SumW'(r_s2_ayy);
            r_s3_t1   <= TermW'(r_s2_bxx) * TermW'($signed({1'b0, r_s2_ayy}));
            r_s3_t2   <= TermW'(r_s2_cxy) * TermW'(r_s2_axy);
            r_s3_t3   <= TermW'(r_s2_byy) * TermW'($signed({1'b0, r_s2_axx}));
            r_s3_flat <= !r_s2_int
                         || ({1'b0, SumW'(r_s2_axx) + SumW'(r_s2_ayy)} <= {r_min, 2'b00});

            begin : num_calc
                logic signed [NumW-1:0] num;
                num = (NumW'(r_s3_t1) <<< 1) - NumW'(r_s3_t2) + (NumW'(r_s3_t3) <<< 1);
                r_s4_neg <= num[NumW-1];
                r_s4_mag <= num[NumW-1] ? MagW'(-num) : MagW'(num);
            end
            r_s4_s    <= r_s3_s;
            r_s4_flat <= r_s3_flat;

            r_s5_p    <= ProdW'(r_grid) * ProdW'(r_s4_mag);
            r_s5_s    <= r_s4_s;
            r_s5_neg  <= r_s4_neg;
            r_s5_flat <= r_s4_flat;

            for (int j = 0; j < SqSteps; j++) begin
                r_sq_root[j] <= n_sq_root[j];
                r_sq_rem[j]  <= n_sq_rem[j];
                r_sq_s[j]    <= (j == 0) ? r_s5_s    : r_sq_s[(j == 0) ? 0 : j-1];
                r_sq_p[j]    <= (j == 0) ? r_s5_p    : r_sq_p[(j == 0) ? 0 : j-1];
                r_sq_neg[j]  <= (j == 0) ? r_s5_neg  : r_sq_neg[(j == 0) ? 0 : j-1];
                r_sq_flat[j] <= (j == 0) ? r_s5_flat : r_sq_flat[(j == 0) ? 0 : j-1];
            end

            r_dn_den  <= DenW'(r_sq_s[SqSteps-1]) * DenW'(r_sq_root[SqSteps-1]);
            r_dn_p    <= r_sq_p[SqSteps-1];
            r_dn_neg  <= r_sq_neg[SqSteps-1];
            r_dn_flat <= r_sq_flat[SqSteps-1];

            r_pc_ovf  <= {3'b000, r_dn_p} >= {r_dn_den, 3'b000};
            r_pc_r    <= DenW'(r_dn_p >> PreShift);
            r_pc_plo  <= r_dn_p[PreShift-1:0];
            r_pc_den  <= r_dn_den;
            r_pc_neg  <= r_dn_neg;
            r_pc_flat <= r_dn_flat;

            for (int k = 0; k < DivSteps; k++) begin
                r_dv_r[k]    <= n_dv_r[k];
                r_dv_q[k]    <= n_dv_q[k];
                r_dv_den[k]  <= (k == 0) ? r_pc_den  : r_dv_den[(k == 0) ? 0 : k-1];
                r_dv_plo[k]  <= (k == 0) ? r_pc_plo  : r_dv_plo[(k == 0) ? 0 : k-1];
                r_dv_ovf[k]  <= (k == 0) ? r_pc_ovf  : r_dv_ovf[(k == 0) ? 0 : k-1];
                r_dv_neg[k]  <= (k == 0) ? r_pc_neg  : r_dv_neg[(k == 0) ? 0 : k-1];
                r_dv_flat[k] <= (k == 0) ? r_pc_flat : r_dv_flat[(k == 0) ? 0 : k-1];
            end

            r_out_k    <= n_out_k;
            r_out_sat  <= n_out_sat;
            r_out_flat <= r_dv_flat[DivSteps-1];
        end
    end

    assign o_valid          = r_out_vld;
    assign o_curvature      = r_out_k;
    assign o_flat_or_border = r_out_flat;
    assign o_saturated      = r_out_sat;

endmodule

>>> sv/lvc_check.sv
// ----------------------------------------------------------------------------
// Level-set curvature checker
// Port-level properties of the curvature pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module lvc_check import lvc_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic signed [ResW-1:0] o_curvature,
    input logic                   o_flat_or_border,
    input logic                   o_saturated
);

    // A result that is not taken stays on the port unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_curvature))
        else $error("output transfer dropped or changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output backpressure");

    a_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_flat_or_border |-> o_curvature == 0 && !o_saturated)
        else $error("flat or border result is not zero");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            o_curvature == 32'sh7FFF_FFFF || o_curvature == 32'sh8000_0000)
        else $error("saturated result is not a range limit");

endmodule

bind level_set_curvature lvc_check u_lvc_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_curvature      (o_curvature),
    .o_flat_or_border (o_flat_or_border),
    .o_saturated      (o_saturated)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Level-set curvature testbench
// Drives 3x3 neighborhoods through the valid/ready input channel, predicts the
// Q16.16 curvature and its flags for each accepted cell or takes them typed in, and checks every
// result in order. The input and output sides both idle and stall at random,
// and the two registers are changed between phases.
// ----------------------------------------------------------------------------
module testbench import lvc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [SampleW-1:0] phi [9];
        logic                      interior;
    } t_cell;

    typedef struct {
        logic signed [ResW-1:0] curv;
        logic                   flat;
        logic                   sat;
    } t_kappa;

    typedef struct {
        t_cell  c;
        logic   known;
        t_kappa k;
    } t_row;

    localparam int WatchLimit  = 3000;
    localparam int SettleWait  = 90;
    localparam int PhaseCount  = 7;
    localparam int PhaseItems  = 250;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic                      i_cfg_idx;
    logic [CfgW-1:0]           i_cfg_data;
    logic                      i_valid;
    logic                      o_ready;
    logic signed [SampleW-1:0] i_phi [9];
    logic                      i_interior;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [ResW-1:0]    o_curvature;
    logic                      o_flat_or_border;
    logic                      o_saturated;

    logic [GridW-1:0] grid_reg;
    logic [31:0]      thresh_reg;
    t_kappa           kappa_q [$];
    int               errors;
    int               idle_cycles;
    bit               no_idle;

    level_set_curvature dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_phi_center     (i_phi[0]),
        .i_phi_left       (i_phi[1]),
        .i_phi_right      (i_phi[2]),
        .i_phi_down       (i_phi[3]),
        .i_phi_up         (i_phi[4]),
        .i_phi_right_up   (i_phi[5]),
        .i_phi_right_down (i_phi[6]),
        .i_phi_left_up    (i_phi[7]),
        .i_phi_left_down  (i_phi[8]),
        .i_interior       (i_interior),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_curvature      (o_curvature),
        .o_flat_or_border (o_flat_or_border),
        .o_saturated      (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_kappa mean_curvature(t_cell c);
        t_kappa      k;
        longint      ctr, lft, rgt, dn, up, ax, ay, bxx, byy, cxy, num;
        logic [63:0] s, mag, p, sq, den, lim, q, rem, m;
        bit          neg, clip;
        ctr = c.phi[0];
        lft = c.phi[1];
        rgt = c.phi[2];
        dn  = c.phi[3];
        up  = c.phi[4];
        ax  = rgt - lft;
        ay  = up - dn;
        bxx = rgt - 2 * ctr + lft;
        byy = up - 2 * ctr + dn;
        cxy = longint'(c.phi[5]) - c.phi[6] - c.phi[7] + c.phi[8];
        s   = 64'(ax * ax) + 64'(ay * ay);
        k.curv = '0;
        k.flat = 1'b0;
        k.sat  = 1'b0;
        if (!c.interior || s <= {30'd0, thresh_reg, 2'b00}) begin
            k.flat = 1'b1;
            return k;
        end
        num  = 2 * bxx * ay * ay - cxy * ax * ay + 2 * byy * ax * ax;
        neg  = num < 0;
        mag  = neg ? 64'(-num) : 64'(num);
        p    = 64'(grid_reg) * mag;
        sq   = int_sqrt(s << (2 * SqrtFrac));
        den  = s * sq;
        lim  = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
        q    = p / den;
        rem  = p % den;
        clip = 1'b0;
        m    = 0;
        if (q >= (64'd1 << 32)) begin
            clip = 1'b1;
        end else begin
            for (int i = 0; i < 30; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    q = q | 64'd1;
                end
            end
            m = (q + 1) >> 1;
            if (m > lim) clip = 1'b1;
        end
        if (clip) m = lim;
        k.curv = neg ? ResW'(0 - m) : ResW'(m);
        k.sat  = clip;
        return k;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic write_reg(logic idx, logic [CfgW-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CfgGridSize) grid_reg = data[GridW-1:0];
        else thresh_reg = data;
    endtask

    function automatic int gap();
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic send_cell(t_cell c, bit known, t_kappa k);
        repeat (gap()) @(negedge i_clk);
        i_phi      = c.phi;
        i_interior = c.interior;
        i_valid    = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        kappa_q.push_back(known ? k : mean_curvature(c));
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic logic signed [SampleW-1:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return SampleW'(v);
    endfunction

    function automatic logic signed [SampleW-1:0] edge_sample();
        case ($urandom_range(0, 3))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'sh0000;
            default: return SampleW'($urandom);
        endcase
    endfunction

    // Mostly a smooth patch, a quadratic surface with random slope and bending, so
    // that most cells pass the gradient threshold and reach the divider; else random or extreme samples.
    function automatic t_cell random_cell();
        t_cell  c;
        longint base, gx, gy, hxx, hyy, hxy;
        int     kind, sc;
        kind = $urandom_range(0, 9);
        sc   = $urandom_range(0, 14);
        base = $signed($urandom_range(0, 65535)) - 32768;
        gx   = ($signed($urandom_range(0, 65535)) - 32768) >>> sc;
        gy   = ($signed($urandom_range(0, 65535)) - 32768) >>> sc;
        hxx  = ($signed($urandom_range(0, 65535)) - 32768) >>> $urandom_range(0, 15);
        hyy  = ($signed($urandom_range(0, 65535)) - 32768) >>> $urandom_range(0, 15);
        hxy  = ($signed($urandom_range(0, 65535)) - 32768) >>> $urandom_range(0, 15);
        if (kind < 6) begin
            for (int dx = -1; dx <= 1; dx++)
                for (int dy = -1; dy <= 1; dy++) begin
                    int idx;
                    idx = (dx == 0 && dy == 0) ? 0 : (dy == 0) ? (dx < 0 ? 1 : 2) :
                          (dx == 0) ? (dy < 0 ? 3 : 4) :
                          (dx > 0) ? (dy > 0 ? 5 : 6) : (dy > 0 ? 7 : 8);
                    c.phi[idx] = clamp16(base + gx * dx + gy * dy
                                         + (hxx * dx * dx + hyy * dy * dy) / 2
                                         + hxy * dx * dy);
                end
        end else if (kind < 8) begin
            foreach (c.phi[i]) c.phi[i] = SampleW'($urandom);
        end else begin
            foreach (c.phi[i]) c.phi[i] = edge_sample();
        end
        c.interior = ($urandom_range(0, 9) != 0);
        return c;
    endfunction

    function automatic t_row mk_row(longint v0, longint v1, longint v2, longint v3,
                                    longint v4, longint v5, longint v6, longint v7,
                                    longint v8, bit in_cell, bit known,
                                    logic [31:0] kc, bit kf, bit ks);
        t_row r;
        r.c.phi = '{SampleW'(v0), SampleW'(v1), SampleW'(v2), SampleW'(v3),
                    SampleW'(v4), SampleW'(v5), SampleW'(v6), SampleW'(v7), SampleW'(v8)};
        r.c.interior = in_cell;
        r.known  = known;
        r.k.curv = kc;
        r.k.flat = kf;
        r.k.sat  = ks;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (kappa_q.size() == 0) begin
                report("unexpected result", o_curvature, 0);
            end else begin
                t_kappa e;
                e = kappa_q.pop_front();
                if (o_curvature !== e.curv) report("curvature", o_curvature, e.curv);
                if (o_flat_or_border !== e.flat)
                    report("flat_or_border", o_flat_or_border, e.flat);
                if (o_saturated !== e.sat) report("saturated", o_saturated, e.sat);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(negedge i_clk);
            i_ready = 1'b0;
            repeat (gap()) @(negedge i_clk);
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        t_row   rows [$];
        t_kappa none;
        logic [GridW-1:0] grids [4];
        logic [31:0]      threshes [4];
        errors      = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CfgGridSize;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_interior  = 1'b0;
        foreach (i_phi[i]) i_phi[i] = '0;
        grid_reg    = 11'd128;
        thresh_reg  = 32'd0;
        none.curv = '0;
        none.flat = 1'b0;
        none.sat  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Border, flat, zero-curvature and clipped cells are typed in; the rest are predicted.
        rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0));
        rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 1, 0));
        rows.push_back(mk_row(32767, -32768, 32767, -32768, 32767, -32768, 32767,
                              -32768, 32767, 0, 1, 0, 1, 0));
        rows.push_back(mk_row(0, -32768, 32767, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0));
        rows.push_back(mk_row(-32768, 0, 1, 0, 0, 0, 0, 0, 0, 1, 1, 32'h7fffffff, 0, 1));
        rows.push_back(mk_row(32767, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(-32768, 32767, -32768, 32767, -32768, 32767, -32768,
                              32767, -32768, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(32767, -32768, 32767, -32768, 32767, 32767, -32768,
                              -32768, 32767, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(1000, 900, 1100, 800, 1200, 1400, 1000, 1000, 600, 1, 0,
                              0, 0, 0));
        rows.push_back(mk_row(-16384, -8192, -8192, -8192, -8192, 0, 0, 0, 0, 1, 0,
                              0, 0, 0));
        rows.push_back(mk_row(100, 0, 200, 50, 150, 300, 100, 100, -100, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(5, 4, 6, 5, 5, 6, 6, 4, 4, 1, 0, 0, 0, 0));
        foreach (rows[i]) send_cell(rows[i].c, rows[i].known, rows[i].k);

        grids    = '{11'd3, 11'd1024, 11'd0, 11'd2047};
        threshes = '{32'd0, 32'hffffffff, 32'd1, 32'd0};
        for (int ph = 0; ph < PhaseCount; ph++) begin
            wait (kappa_q.size() == 0);
            repeat (SettleWait) @(posedge i_clk);
            if (ph < 4) begin
                write_reg(CfgGridSize, grids[ph]);
                write_reg(CfgMinGradSq, threshes[ph]);
            end else begin
                write_reg(CfgGridSize, $urandom_range(0, 2047));
                write_reg(CfgMinGradSq, (ph == 6) ? $urandom
                                                  : $urandom_range(0, 1 << $urandom_range(0, 31)));
            end
            no_idle = (ph % 3 == 1);
            for (int n = 0; n < PhaseItems; n++) send_cell(random_cell(), 1'b0, none);
        end

        wait (kappa_q.size() == 0);
        repeat (SettleWait) @(posedge i_clk);
        if (errors == 0 && kappa_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
